@@ rtl/linear_search_set_table_unit_macros.svh @@
// Assertion macros shared by the set table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LINEAR_SEARCH_SET_TABLE_UNIT_MACROS_SVH
`define LINEAR_SEARCH_SET_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define LSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set table: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define LSST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set table: next-cycle check failed");
`else
`define LSST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lsst_pkg.sv @@
// Shared codes and controller/datapath interface types for the set table.
// No dependencies.
`timescale 1ns / 1ps
package lsst_pkg;

  // Operation codes (code 3 is a no-op)
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Port field widths
  localparam int unsigned IN_VAL_W = 32;
  localparam int unsigned OUT_CNT_W = 5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the input word, restart the scan
    logic srch;   // scan step looking for the value
    logic shift;  // scan step moving later entries down
    logic fin;    // apply the update and load the result word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;     // captured operation
    logic       match;    // scan hit this cycle
    logic       scan_end; // no read left to issue or check
    logic       out_free; // result register can take a word
  } sts_t;

endpackage

@@ rtl/lsst_ctrl.sv @@
// Sequencer for the set table: idle, search, shift and finish phases.
// Depends on lsst_pkg.
`timescale 1ns / 1ps
module lsst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  output logic             in_ready,
  input  lsst_pkg::sts_t   sts,
  output lsst_pkg::cmd_t   cmd
);
  import lsst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          if (in_mode == OP_INSERT || in_mode == OP_ERASE) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SEARCH: begin
        cmd.srch = 1'b1;
        if (sts.match) begin
          state_nxt = (sts.mode == OP_ERASE) ? S_SHIFT : S_FIN;
        end else if (sts.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/lsst_dpath.sv @@
// Datapath for the set table: entry memory, scan counters, fill count and
// result register. Depends on lsst_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "linear_search_set_table_unit_macros.svh"
module lsst_dpath #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lsst_pkg::cmd_t                  cmd,
  output lsst_pkg::sts_t                  sts,
  input  logic [1:0]                      in_mode,
  input  logic [lsst_pkg::IN_VAL_W-1:0]   in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [lsst_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                            out_is_empty
);
  import lsst_pkg::*;

  localparam int unsigned SW = (VALUE_WIDTH < IN_VAL_W) ? VALUE_WIDTH : IN_VAL_W;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // entry memory, packed at 0..count-1
  logic [SW-1:0] mem [CAPACITY];
  logic [SW-1:0] rd_data_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;

  logic [1:0]    mode_r, mode_nxt;
  logic [SW-1:0] val_r, val_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          hit_r, hit_nxt;
  logic          match, scanning, append_ok;

  logic                 out_vld_r, out_vld_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_count_r, out_count_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [CW+OUT_CNT_W-1:0] count_ext;
  logic [CW-1:0]           fin_count;

  // scan compare and read issue
  assign match     = cmd.srch && rd_vld_r && (rd_data_r == val_r);
  assign scanning  = (cmd.srch && !match) || cmd.shift;
  assign rd_en     = scanning && (idx_r < count_r);
  assign append_ok = (mode_r == OP_INSERT) && !hit_r && (count_r < CAP);

  // single write port: shift moves entry down, finish appends
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = val_r;
    if (cmd.shift && rd_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = AW'(cmp_idx_r - CW'(1));
      wr_data = rd_data_r;
    end else if (cmd.fin && append_ok) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // operation and scan registers
  always_comb begin
    mode_nxt    = mode_r;
    val_nxt     = val_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    rd_vld_nxt  = 1'b0;
    hit_nxt     = hit_r;
    if (cmd.load) begin
      mode_nxt = in_mode;
      val_nxt  = in_value[SW-1:0];
      idx_nxt  = '0;
      hit_nxt  = 1'b0;
    end else if (match) begin
      // shift starts with the entry after the hit
      hit_nxt = 1'b1;
      idx_nxt = cmp_idx_r + CW'(1);
    end else if (rd_en) begin
      idx_nxt     = idx_r + CW'(1);
      cmp_idx_nxt = idx_r;
      rd_vld_nxt  = 1'b1;
    end
  end

  // count after the operation
  always_comb begin
    fin_count = count_r;
    case (mode_r)
      OP_INSERT: if (append_ok) fin_count = count_r + CW'(1);
      OP_ERASE:  if (hit_r)     fin_count = count_r - CW'(1);
      OP_CLEAR:  fin_count = '0;
      default:   fin_count = count_r;
    endcase
  end

  assign count_nxt = cmd.fin ? fin_count : count_r;
  assign count_ext = {{OUT_CNT_W{1'b0}}, fin_count};

  // result word
  always_comb begin
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_vld_nxt    = out_ready ? 1'b0 : out_vld_r;
    if (cmd.fin) begin
      out_vld_nxt    = 1'b1;
      out_count_nxt  = count_ext[OUT_CNT_W-1:0];
      out_empty_nxt  = (fin_count == '0);
      out_status_nxt = ST_DONE;
      if (mode_r == OP_INSERT) begin
        if (hit_r) begin
          out_status_nxt = ST_DUP;
        end else if (!append_ok) begin
          out_status_nxt = ST_FULL;
        end
      end else if (mode_r == OP_ERASE && !hit_r) begin
        out_status_nxt = ST_MISSING;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign sts.mode     = mode_r;
  assign sts.match    = match;
  assign sts.scan_end = !rd_vld_r && (idx_r >= count_r);
  assign sts.out_free = !out_vld_r || out_ready;

  assign out_valid    = out_vld_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_empty_r;

  // checks
  `LSST_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, count_r <= CAP)
  `LSST_ASSERT_IMP(a_full_cnt, clk, rst_n, cmd.fin && !hit_r && mode_r == OP_INSERT && !append_ok, count_r == CAP)
  `LSST_ASSERT_IMP(a_hit_range, clk, rst_n, match, cmp_idx_r < count_r)
  `LSST_ASSERT_IMP(a_shift_wr, clk, rst_n, cmd.shift && rd_vld_r, hit_r && cmp_idx_r != '0 && cmp_idx_r < count_r)

endmodule

@@ rtl/linear_search_set_table_unit.sv @@
// Top level of the set table: sequencer plus datapath on stream ports.
// Depends on lsst_pkg, lsst_ctrl and lsst_dpath.
//
//  port group  | dir | tdata                          | tuser
//  in_*        | in  | [31:0] value                   | [1:0] mode
//  out_*       | out | [4:0] count, [5] is_empty      | [1:0] status
//
// Insert/erase scan the n stored entries through one registered memory read
// port. An erase that hits goes on from the hit, moving each later entry down.
// Clear and the unused code go straight to the finish phase; each result shows as
// the block returns to idle. Result goes to an output register, so a new word is taken
// while the last result still waits; a stalled result holds the finish phase only.
// Synchronous reset clears the count; no fill pass.
`timescale 1ns / 1ps
module linear_search_set_table_unit #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] count, [5] is_empty, [7:6] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import lsst_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  logic [OUT_CNT_W-1:0] res_count;
  logic                 res_empty;

  lsst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsst_dpath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_tuser),
    .in_value     (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_tuser),
    .out_count    (res_count),
    .out_is_empty (res_empty)
  );

  // pack the result word
  assign out_tdata = {2'b00, res_empty, res_count};

endmodule

@@ bench/tb_linear_search_set_table_unit.sv @@
// Self-checking testbench for the set table unit: stream driver, stream sink and a
// scoreboard that predicts every result word from its own copy of the table.
// Depends on lsst_pkg and linear_search_set_table_unit.
`timescale 1ns / 1ps
module tb_linear_search_set_table_unit;
  import lsst_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned RANDOM_WORDS = 1325;
  localparam int unsigned POOL_SIZE = 24;
  localparam logic [1:0] OP_NOP = 2'd3;   // unused code, leaves the table unchanged

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
    logic       is_empty;
  } set_result_t;

  // Table predictor and queue of result words still owed by the block
  class set_table_scoreboard;
    logic [31:0]  stored[TABLE_DEPTH];
    int unsigned  fill;
    set_result_t  owed_q[$];
    int unsigned  errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function int find_slot(input logic [31:0] val);
      for (int i = 0; i < int'(fill); i++)
        if (stored[i] == val) return i;
      return -1;
    endfunction

    // Apply an accepted input word to the table copy and queue its result
    function void note_word(input logic [1:0] op, input logic [31:0] val);
      set_result_t res;
      int slot;
      res.status = ST_DONE;
      slot = find_slot(val);
      case (op)
        OP_INSERT: begin
          if (slot >= 0) res.status = ST_DUP;
          else if (fill >= TABLE_DEPTH) res.status = ST_FULL;
          else begin
            stored[fill] = val;
            fill++;
          end
        end
        OP_ERASE: begin
          if (slot < 0) res.status = ST_MISSING;
          else begin
            // close the gap left by the erased entry
            for (int j = slot; j + 1 < int'(fill); j++) stored[j] = stored[j + 1];
            fill--;
          end
        end
        OP_CLEAR: fill = 0;
        default: ;
      endcase
      res.count = fill[4:0];
      res.is_empty = (fill == 0);
      owed_q.push_back(res);
    endfunction

    // Compare an accepted result word with the oldest prediction
    function void check_word(input logic [7:0] data, input logic [1:0] user);
      set_result_t exp_res;
      if (owed_q.size() == 0) begin
        $error("result word with none expected: tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (user !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, user);
        errors++;
      end
      if (data[4:0] !== exp_res.count) begin
        $error("count: expected %0d, got %0d", exp_res.count, data[4:0]);
        errors++;
      end
      if (data[5] !== exp_res.is_empty) begin
        $error("is_empty: expected %0d, got %0d", exp_res.is_empty, data[5]);
        errors++;
      end
      if (data[7:6] !== 2'b00) begin
        $error("tdata padding: expected 0, got %0d", data[7:6]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [4:0] count, [5] is_empty, [7:6] zero
  logic [1:0]  out_tuser;  // [1:0] status

  set_table_scoreboard sb;
  logic        steady;        // no idling on either side while set
  int unsigned stall_cycles;
  logic [31:0] value_pool[POOL_SIZE];

  linear_search_set_table_unit #(
    .CAPACITY(TABLE_DEPTH),
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sink backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
  end

  // Monitor: both handshakes sampled on the rising edge, plus the stall counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one word; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [1:0] op, input logic [31:0] val);
    while (!steady && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Operation mix leaning toward inserts when fill_pct is high
  function automatic logic [1:0] pick_op(input int unsigned fill_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < fill_pct) return OP_INSERT;
    if (r < 95) return OP_ERASE;
    if (r < 97) return OP_CLEAR;
    return OP_NOP;
  endfunction

  // Erase mostly hits a stored entry; otherwise draw from the pool or fully random
  function automatic logic [31:0] pick_value(input logic [1:0] op);
    if (op == OP_ERASE && sb.fill > 0 && $urandom_range(99) < 70)
      return sb.stored[$urandom_range(sb.fill - 1)];
    if ($urandom_range(99) < 10) return $urandom;
    return value_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  initial begin
    int unsigned fill_pct;
    logic [1:0]  op;
    sb = new();
    steady = 1'b0;
    stall_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_NOP;
    out_tready = 1'b0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-table cases, extremes, duplicate, full table, shift, clear
    send_word(OP_ERASE, 32'h1234_5678);
    send_word(OP_NOP, 32'hFFFF_FFFF);
    send_word(OP_INSERT, value_pool[0]);
    send_word(OP_INSERT, value_pool[1]);
    send_word(OP_INSERT, value_pool[0]);
    for (int i = 2; i < TABLE_DEPTH; i++) send_word(OP_INSERT, value_pool[i]);
    send_word(OP_INSERT, value_pool[TABLE_DEPTH]);
    send_word(OP_INSERT, value_pool[1]);
    send_word(OP_NOP, 32'h0);
    send_word(OP_ERASE, value_pool[7]);
    send_word(OP_ERASE, value_pool[7]);
    send_word(OP_CLEAR, 32'hA5A5_A5A5);
    send_word(OP_INSERT, value_pool[3]);

    // Random bursts, each leaning toward filling or draining the table
    fill_pct = 55;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) fill_pct = ($urandom_range(1)) ? 75 : 35;
      steady = (n >= 500 && n < 700);
      op = pick_op(fill_pct);
      send_word(op, pick_value(op));
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      $error("%0d result words never arrived", sb.owed_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ linear_search_set_table_unit.f @@
+incdir+rtl
rtl/lsst_pkg.sv
rtl/lsst_ctrl.sv
rtl/lsst_dpath.sv
rtl/linear_search_set_table_unit.sv
bench/tb_linear_search_set_table_unit.sv
